/* sv/sdaf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sdaf_pkg: shared types and constants of the decimal ASCII formatter
// Character codes, field widths, the controller state type and the
// add-3 correction used by the bit-serial binary to BCD converter.
// ----------------------------------------------------------------------------
package sdaf_pkg;

  localparam int VALUE_W  = 32;
  localparam int CHAR_W   = 8;
  localparam int DIGITS   = 10;
  localparam int BCD_W    = 4 * DIGITS;
  localparam int BITCNT_W = $clog2(VALUE_W);
  localparam int DIGCNT_W = $clog2(DIGITS + 1);

  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'd57;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // Add 3 to every BCD digit of 5 or more, ahead of the next left shift
  function automatic logic [BCD_W-1:0] dabble_adj(input logic [BCD_W-1:0] bcd);
    logic [BCD_W-1:0] res;
    res = bcd;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* sv/signed_decimal_ascii_formatter_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// signed_decimal_ascii_formatter_top: signed 32-bit integer to decimal ASCII
// Converts one two's complement value into its decimal characters, most
// significant digit first, with a leading minus sign for negative values.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_value and raise start; the beat is taken at a rising edge
//   where start is high and busy is low. busy then stays high until the last
//   character has been produced.
//   Output: each character appears on out_char_code for one cycle with
//   out_valid high; out_is_last marks the final character of the number.
//   The receiver cannot stall, so every strobed character must be taken.
// Timing:
//   A negative value shows '-' in the cycle after the input beat. The
//   magnitude then goes through a bit-serial double-dabble converter, one
//   bit per cycle, and the 10 BCD digits are scanned one per cycle, leading
//   zeros dropped without a strobe. busy drops in the cycle where the last
//   character is shown, so a new beat may be taken in that same cycle.
// Reset: rst_n is synchronous, active low; it returns the controller to idle
//   and drops out_valid. There is no other state to clear.
// ----------------------------------------------------------------------------
module signed_decimal_ascii_formatter_top
  import sdaf_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic signed [VALUE_W-1:0] in_value,
  output logic                           out_valid,
  output logic        [CHAR_W-1:0]       out_char_code,
  output logic                           out_is_last
);

  state_t                state_r,    state_nxt;
  logic [VALUE_W-1:0]    bin_r,      bin_nxt;
  logic [BCD_W-1:0]      bcd_r,      bcd_nxt;
  logic [BITCNT_W-1:0]   bit_cnt_r,  bit_cnt_nxt;
  logic [DIGCNT_W-1:0]   dig_cnt_r,  dig_cnt_nxt;
  logic                  started_r,  started_nxt;
  logic                  valid_r,    valid_nxt;
  logic [CHAR_W-1:0]     char_r,     char_nxt;
  logic                  last_r,     last_nxt;

  logic [VALUE_W-1:0]    raw;
  logic [BCD_W-1:0]      bcd_adj;
  logic [3:0]            top_dig;
  logic                  lead_zero;
  logic                  final_dig;

  assign raw       = VALUE_W'(in_value);
  assign bcd_adj   = dabble_adj(bcd_r);
  assign top_dig   = bcd_r[BCD_W-1 -: 4];
  assign final_dig = (dig_cnt_r == DIGCNT_W'(1));
  assign lead_zero = (top_dig == 4'd0) && !started_r && !final_dig;

  // Next-state and datapath logic
  always_comb begin
    state_nxt   = state_r;
    bin_nxt     = bin_r;
    bcd_nxt     = bcd_r;
    bit_cnt_nxt = bit_cnt_r;
    dig_cnt_nxt = dig_cnt_r;
    started_nxt = started_r;
    valid_nxt   = 1'b0;
    char_nxt    = char_r;
    last_nxt    = last_r;
    case (state_r)
      ST_IDLE: begin
        // take the beat, load the magnitude, emit the sign if needed
        if (start) begin
          bin_nxt     = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
          bcd_nxt     = '0;
          bit_cnt_nxt = '0;
          state_nxt   = ST_CONV;
          if (raw[VALUE_W-1]) begin
            valid_nxt = 1'b1;
            char_nxt  = ASCII_MINUS;
            last_nxt  = 1'b0;
          end
        end
      end
      ST_CONV: begin
        // correct digits, then shift one binary bit into the BCD register
        bcd_nxt     = {bcd_adj[BCD_W-2:0], bin_r[VALUE_W-1]};
        bin_nxt     = {bin_r[VALUE_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + BITCNT_W'(1);
        if (bit_cnt_r == BITCNT_W'(VALUE_W - 1)) begin
          dig_cnt_nxt = DIGCNT_W'(DIGITS);
          started_nxt = 1'b0;
          state_nxt   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // drop leading zeros, strobe all other digits
        if (!lead_zero) begin
          valid_nxt   = 1'b1;
          char_nxt    = ASCII_ZERO + {4'd0, top_dig};
          last_nxt    = final_dig;
          started_nxt = 1'b1;
        end
        bcd_nxt     = {bcd_r[BCD_W-5:0], 4'd0};
        dig_cnt_nxt = dig_cnt_r - DIGCNT_W'(1);
        if (final_dig) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    bin_r     <= bin_nxt;
    bcd_r     <= bcd_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    dig_cnt_r <= dig_cnt_nxt;
    started_r <= started_nxt;
    char_r    <= char_nxt;
    last_r    <= last_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = valid_r;
  assign out_char_code = char_r;
  assign out_is_last   = last_r;

endmodule
`default_nettype wire

/* sv/sdaf_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sdaf_checker: port-level checks for the decimal ASCII formatter
// Watches the command and result ports and flags sequencing slips.
// ----------------------------------------------------------------------------
module sdaf_checker
  import sdaf_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic signed [VALUE_W-1:0] in_value,
  input wire logic                      out_valid,
  input wire logic        [CHAR_W-1:0]  out_char_code,
  input wire logic                      out_is_last
);

  // every strobed character is a minus sign or a digit
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_code == ASCII_MINUS) ||
                  ((out_char_code >= ASCII_ZERO) && (out_char_code <= ASCII_NINE)))
    else $error("character outside minus and digit codes");

  // an accepted beat makes the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after input beat");

  // a negative value opens with the minus sign
  a_minus_first: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_value[VALUE_W-1]) |=>
      (out_valid && (out_char_code == ASCII_MINUS) && !out_is_last))
    else $error("minus sign missing after negative input");

  // a non-negative value shows nothing in the following cycle
  a_no_early_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_value[VALUE_W-1]) |=> !out_valid)
    else $error("digit strobed before conversion finished");

  // more characters follow only while the block is still busy
  a_more_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_last) |-> busy)
    else $error("non-final character without busy");

endmodule

bind signed_decimal_ascii_formatter_top sdaf_checker u_sdaf_checker (.*);
`default_nettype wire

/* dv/sdaf_char_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sdaf_char_checker: character stream checker for the decimal ASCII formatter
// Watches the input beats and the output strobes of the formatter. For each
// accepted value it builds the decimal text, sign first, and queues the
// expected characters; each strobed character is compared with the oldest
// queued one, code and last flag separately.
// ----------------------------------------------------------------------------
module sdaf_char_checker
  import sdaf_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic                      busy,
  input  wire logic signed [VALUE_W-1:0] in_value,
  input  wire logic                      out_valid,
  input  wire logic        [CHAR_W-1:0]  out_char_code,
  input  wire logic                      out_is_last,
  output int                             mismatch_count,
  output int                             chars_pending
);

  localparam logic [VALUE_W-1:0] DEC_BASE = 32'd10;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_beat_t;

  char_beat_t expected_chars[$];
  int         char_index;

  // Print one line and count it
  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  // Queue the decimal text of one value: optional minus, then digits MSD first
  task automatic push_decimal_text(input logic [VALUE_W-1:0] raw);
    logic [VALUE_W-1:0] mag;
    logic [3:0]         digit_buf [DIGITS];
    int                 ndig;
    char_beat_t         ch;
    mag  = raw;
    ndig = 0;
    if (raw[VALUE_W-1]) begin
      ch.code = ASCII_MINUS;
      ch.last = 1'b0;
      expected_chars.push_back(ch);
      // Two's complement negate; the most negative value wraps to 2^31
      mag = {VALUE_W{1'b0}} - raw;
    end
    do begin
      digit_buf[ndig] = 4'(mag % DEC_BASE);
      mag = mag / DEC_BASE;
      ndig++;
    end while (mag != 0 && ndig < DIGITS);
    for (int k = ndig - 1; k >= 0; k--) begin
      ch.code = ASCII_ZERO + CHAR_W'(digit_buf[k]);
      ch.last = (k == 0);
      expected_chars.push_back(ch);
    end
  endtask

  initial begin
    mismatch_count = 0;
    chars_pending  = 0;
    char_index     = 0;
  end

  // Predict on every input beat, compare on every strobe
  always @(posedge clk) begin
    char_beat_t want;
    if (rst_n) begin
      if (start && !busy) begin
        push_decimal_text(in_value);
      end
      if (out_valid) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("char #%0d code %0d last %0b with nothing expected",
                                    char_index, out_char_code, out_is_last));
        end else begin
          want = expected_chars.pop_front();
          if (out_char_code !== want.code) begin
            report_mismatch($sformatf("char #%0d code %0d, expected %0d",
                                      char_index, out_char_code, want.code));
          end
          if (out_is_last !== want.last) begin
            report_mismatch($sformatf("char #%0d is_last %0b, expected %0b",
                                      char_index, out_is_last, want.last));
          end
        end
        char_index++;
      end
    end
    chars_pending <= expected_chars.size();
  end

endmodule
`default_nettype wire

/* dv/tb_signed_decimal_ascii_formatter_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_signed_decimal_ascii_formatter_top: testbench of the decimal formatter
// Sends directed edge values, then random values of every length and sign,
// with random gaps on the start line except in the closing stretch. A
// checker beside the block predicts every character; the run ends with a
// verdict once all characters have drained, or on a stall watchdog.
// ----------------------------------------------------------------------------
module tb_signed_decimal_ascii_formatter_top;
  import sdaf_pkg::*;

  localparam int RANDOM_ITEMS = 350;
  localparam int QUIET_TAIL   = 50;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 60;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic signed [VALUE_W-1:0] in_value;
  logic                      out_valid;
  logic        [CHAR_W-1:0]  out_char_code;
  logic                      out_is_last;
  int                        mismatch_count;
  int                        chars_pending;
  int                        stall_cycles;
  bit                        quiet_tail;

  int directed_values[] = '{
    0, 1, -1, 9, 10, -9, -10, 99, 100, -100, 12345, -67890,
    999999999, 1000000000, -999999999, -1000000000,
    2147483647, 32'sh8000_0000, -2147483647, 1073741824
  };

  signed_decimal_ascii_formatter_top DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_char_code(out_char_code),
    .out_is_last  (out_is_last)
  );

  sdaf_char_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_is_last   (out_is_last),
    .mismatch_count(mismatch_count),
    .chars_pending (chars_pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Pick a value: full-range noise, a random digit count, or an edge value
  function automatic logic [VALUE_W-1:0] pick_value();
    int              sel;
    int              ndig;
    longint unsigned span;
    longint unsigned mag;
    logic [VALUE_W-1:0] v;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      v = $urandom;
    end else if (sel < 9) begin
      ndig = $urandom_range(1, 10);
      span = 1;
      repeat (ndig) span = span * 10;
      mag = {$urandom, $urandom};
      mag = mag % span;
      v = 32'(mag);
      if ($urandom_range(0, 1) == 1) v = {VALUE_W{1'b0}} - v;
    end else begin
      v = directed_values[$urandom_range(0, directed_values.size() - 1)];
    end
    return v;
  endfunction

  // Optionally drop start for a short burst, then hold a beat until taken
  task automatic send_value(input logic [VALUE_W-1:0] v);
    if (!quiet_tail && $urandom_range(0, 2) == 0) begin
      start    <= 1'b0;
      in_value <= $urandom;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start    <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (busy);
  endtask

  // Stop the run if neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_value     = '0;
    stall_cycles = 0;
    quiet_tail   = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, zero, digit-count boundaries, both signs
    foreach (directed_values[i]) send_value(directed_values[i]);

    // Random: mixed lengths and signs, no gaps in the closing stretch
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet_tail = (n >= RANDOM_ITEMS - QUIET_TAIL);
      send_value(pick_value());
    end
    start <= 1'b0;

    // Drain outstanding characters, then let the block settle
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && chars_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
